// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the vector unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define V3AU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define V3AU_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define V3AU_ASSERT(lbl, prop, msg)
`define V3AU_NEVER(lbl, expr, msg)
`endif
`endif

// File: sv/v3au_pkg.sv
// Types, codes and helpers for the three-component vector unit.
// No dependencies; used by every module of the block.
package v3au_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_NEG  = 3'd2,
    OP_EQ   = 3'd3,
    OP_ZERO = 3'd4,
    OP_MAG  = 3'd5,
    OP_NORM = 3'd6,
    OP_DIST = 3'd7
  } op_e;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // Per-item side data carried along the pipeline
  typedef struct packed {
    op_e              op;
    logic [2:0][31:0] a;
    logic [2:0][31:0] r;
    logic [31:0]      scalar;
    logic             flag;
    logic             sat;
  } item_t;

  // Clamp a 33-bit signed value to 32 bits; bit 32 of the result is the sat flag
  function automatic logic [32:0] clamp33(input logic [32:0] v);
    logic [32:0] res;
    if (v[32] != v[31]) begin
      res = {1'b1, (v[32] ? S32_MIN : S32_MAX)};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

// File: sv/v3au_front.sv
// Front stages: input register, simple ops, absolute values, squares, sum.
// Depends on v3au_pkg.
module v3au_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  v3au_pkg::op_e          op_i,
  input  logic [2:0][31:0]       a_i,
  input  logic [2:0][31:0]       b_i,
  output logic                   valid_o,
  output v3au_pkg::item_t        item_o,
  output logic [63:0]            sum_o
);

  logic             va_q, vb_q, vc_q, vd_q;
  v3au_pkg::op_e    opa_q;
  logic [2:0][31:0] aa_q, ba_q;
  v3au_pkg::item_t  itb_d, itb_q, itc_q, itd_d, itd_q;
  logic [2:0][31:0] mb_d, mb_q;
  logic [2:0][63:0] sqc_q;
  logic [65:0]      sum_d;
  logic [63:0]      sum_q;

  // Stage B: simple operations and the vector fed to the magnitude path
  always_comb begin
    logic [32:0] s, v, m, c;
    logic        ovf, big;
    itb_d        = '0;
    itb_d.op     = opa_q;
    itb_d.a      = aa_q;
    ovf          = 1'b0;
    big          = 1'b0;
    for (int i = 0; i < 3; i++) begin
      case (opa_q)
        v3au_pkg::OP_ADD: s = {aa_q[i][31], aa_q[i]} + {ba_q[i][31], ba_q[i]};
        v3au_pkg::OP_SUB: s = {aa_q[i][31], aa_q[i]} - {ba_q[i][31], ba_q[i]};
        default:          s = 33'd0 - {aa_q[i][31], aa_q[i]};
      endcase
      c = v3au_pkg::clamp33(s);
      if (opa_q inside {v3au_pkg::OP_ADD, v3au_pkg::OP_SUB, v3au_pkg::OP_NEG}) begin
        itb_d.r[i] = c[31:0];
        ovf        = ovf | c[32];
      end
      if (opa_q == v3au_pkg::OP_DIST) begin
        v = {aa_q[i][31], aa_q[i]} - {ba_q[i][31], ba_q[i]};
      end else begin
        v = {aa_q[i][31], aa_q[i]};
      end
      m       = v[32] ? (33'd0 - v) : v;
      big     = big | m[32];
      mb_d[i] = m[31:0];
    end
    itb_d.flag = ((opa_q == v3au_pkg::OP_EQ) && (aa_q == ba_q)) ||
                 ((opa_q == v3au_pkg::OP_ZERO) && (aa_q == '0));
    itb_d.sat  = ovf | (big & (opa_q == v3au_pkg::OP_DIST));
  end

  // Stage D: sum of squares, overflow only matters on the magnitude ops
  always_comb begin
    sum_d = {2'b00, sqc_q[0]} + {2'b00, sqc_q[1]} + {2'b00, sqc_q[2]};
    itd_d = itc_q;
    if ((itc_q.op inside {v3au_pkg::OP_MAG, v3au_pkg::OP_NORM, v3au_pkg::OP_DIST})
        && (sum_d[65:64] != 2'b00)) begin
      itd_d.sat = 1'b1;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opa_q <= op_i;
      aa_q  <= a_i;
      ba_q  <= b_i;
      itb_q <= itb_d;
      mb_q  <= mb_d;
      itc_q <= itb_q;
      for (int i = 0; i < 3; i++) begin
        sqc_q[i] <= 64'(mb_q[i]) * 64'(mb_q[i]);
      end
      itd_q <= itd_d;
      sum_q <= sum_d[63:0];
    end
  end

  assign valid_o = vd_q;
  assign item_o  = itd_q;
  assign sum_o   = sum_q;

endmodule

// File: sv/v3au_sqrt.sv
// Pipelined integer square root, one result bit per stage (32 stages).
// Depends on v3au_pkg.
module v3au_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  v3au_pkg::item_t item_i,
  input  logic [63:0]     sum_i,
  output logic            valid_o,
  output v3au_pkg::item_t item_o,
  output logic [31:0]     root_o
);

  localparam int Steps = 32;

  logic            v_q    [Steps];
  logic [63:0]     rem_q  [Steps];
  logic [63:0]     root_q [Steps];
  v3au_pkg::item_t it_q   [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [63:0]     rin, qin, bitv, trial;
    logic            vin, ge;
    v3au_pkg::item_t iin;

    if (s == 0) begin : g_first
      assign rin = sum_i;
      assign qin = '0;
      assign vin = valid_i;
      assign iin = item_i;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign qin = root_q[s-1];
      assign vin = v_q[s-1];
      assign iin = it_q[s-1];
    end

    // One digit: try subtracting root + bit
    assign bitv  = 64'd1 << (62 - 2 * s);
    assign trial = qin + bitv;
    assign ge    = rin >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[s] <= iin;
        if (ge) begin
          rem_q[s]  <= rin - trial;
          root_q[s] <= (qin >> 1) + bitv;
        end else begin
          rem_q[s]  <= rin;
          root_q[s] <= qin >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign item_o  = it_q[Steps-1];
  assign root_o  = root_q[Steps-1][31:0];

endmodule

// File: sv/v3au_div.sv
// Normalize divider (three lanes, one quotient bit per stage) and result assembly.
// Depends on v3au_pkg.
module v3au_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  v3au_pkg::item_t  item_i,
  input  logic [31:0]      root_i,
  output logic             valid_o,
  output logic [2:0][31:0] res_o,
  output logic [31:0]      scalar_o,
  output logic             flag_o,
  output logic [1:0]       status_o
);

  localparam int Steps = 32;

  // Setup stage
  logic             vs_q;
  v3au_pkg::item_t  its_q;
  logic [31:0]      mag_q;
  logic [2:0][63:0] num_q;
  logic [2:0]       neg_q, ovf_q;

  // Quotient stages
  logic             v_q   [Steps];
  v3au_pkg::item_t  it_q  [Steps];
  logic [31:0]      m_q   [Steps];
  logic [2:0][63:0] rem_q [Steps];
  logic [2:0][31:0] quo_q [Steps];
  logic [2:0]       ng_q  [Steps];
  logic [2:0]       ov_q  [Steps];

  // Output register
  logic             vo_q;
  logic [2:0][31:0] res_q;
  logic [31:0]      scal_q;
  logic             flag_q;
  logic [1:0]       st_q;

  // Setup: scalar result, absolute dividends, early overflow check
  v3au_pkg::item_t  its_d;
  logic [2:0][63:0] num_d;
  logic [2:0]       neg_d, ovf_d;

  always_comb begin
    logic [31:0] absa;
    its_d = item_i;
    if (item_i.op == v3au_pkg::OP_MAG || item_i.op == v3au_pkg::OP_DIST) begin
      its_d.scalar = item_i.sat ? 32'hFFFF_FFFF : root_i;
    end else begin
      its_d.scalar = '0;
    end
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = item_i.a[i][31];
      absa     = neg_d[i] ? (32'd0 - item_i.a[i]) : item_i.a[i];
      num_d[i] = {32'd0, absa} << FRAC_BITS;
      ovf_d[i] = num_d[i][63:32] >= root_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en_i) begin
      vs_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      its_q <= its_d;
      mag_q <= root_i;
      num_q <= num_d;
      neg_q <= neg_d;
      ovf_q <= ovf_d;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic             vin;
    v3au_pkg::item_t  iin;
    logic [31:0]      min;
    logic [2:0][63:0] rin;
    logic [2:0][31:0] qin;
    logic [2:0]       nin, oin;
    logic [63:0]      dsh;

    if (k == 0) begin : g_first
      assign vin = vs_q;
      assign iin = its_q;
      assign min = mag_q;
      assign rin = num_q;
      assign qin = '0;
      assign nin = neg_q;
      assign oin = ovf_q;
    end else begin : g_next
      assign vin = v_q[k-1];
      assign iin = it_q[k-1];
      assign min = m_q[k-1];
      assign rin = rem_q[k-1];
      assign qin = quo_q[k-1];
      assign nin = ng_q[k-1];
      assign oin = ov_q[k-1];
    end

    // Divisor aligned to quotient bit 31-k
    assign dsh = {32'd0, min} << (Steps - 1 - k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[k] <= iin;
        m_q[k]  <= min;
        ng_q[k] <= nin;
        ov_q[k] <= oin;
        for (int i = 0; i < 3; i++) begin
          if (rin[i] >= dsh) begin
            rem_q[k][i] <= rin[i] - dsh;
            quo_q[k][i] <= qin[i] | (32'd1 << (Steps - 1 - k));
          end else begin
            rem_q[k][i] <= rin[i];
            quo_q[k][i] <= qin[i];
          end
        end
      end
    end
  end

  // Final: signed clamp of quotients and result assembly
  logic [2:0][31:0] res_d;
  logic [1:0]       st_d;

  always_comb begin
    v3au_pkg::item_t  it;
    logic [2:0][31:0] q;
    logic             sat;
    it    = it_q[Steps-1];
    q     = quo_q[Steps-1];
    sat   = 1'b0;
    res_d = it.r;
    for (int i = 0; i < 3; i++) begin
      if (!ng_q[Steps-1][i]) begin
        if (ov_q[Steps-1][i] || q[i][31]) begin
          res_d[i] = v3au_pkg::S32_MAX;
          sat      = 1'b1;
        end else begin
          res_d[i] = q[i];
        end
      end else if (ov_q[Steps-1][i] || (q[i] > v3au_pkg::S32_MIN)) begin
        res_d[i] = v3au_pkg::S32_MIN;
        sat      = 1'b1;
      end else begin
        res_d[i] = 32'd0 - q[i];
      end
    end
    if (it.op == v3au_pkg::OP_NORM) begin
      if (m_q[Steps-1] == '0) begin
        res_d = '0;
        st_d  = v3au_pkg::ST_DZ;
      end else begin
        st_d  = sat ? v3au_pkg::ST_SAT : v3au_pkg::ST_OK;
      end
    end else begin
      res_d = it.r;
      st_d  = it.sat ? v3au_pkg::ST_SAT : v3au_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      scal_q <= it_q[Steps-1].scalar;
      flag_q <= it_q[Steps-1].flag;
      st_q   <= st_d;
    end
  end

  assign valid_o  = vo_q;
  assign res_o    = res_q;
  assign scalar_o = scal_q;
  assign flag_o   = flag_q;
  assign status_o = st_q;

endmodule

// File: sv/vec3_arithmetic_unit_core.sv
// Three-component vector unit in signed fixed point, top level.
// Depends on v3au_pkg, v3au_front, v3au_sqrt, v3au_div and assert_macros.svh.
//
// Usage:
//   Input channel s_axis: tdata carries a_x, a_y, a_z, b_x, b_y, b_z (32 bits
//   each, lowest first); tuser carries the operation code (add, subtract,
//   negate, equal, is-zero, magnitude, normalize, distance).
//   Output channel m_axis: tdata carries res_x, res_y, res_z, scalar_out;
//   tuser carries test_flag (bit 0) and status (bits 2:1).
//   Every operation takes the same path: 4 front stages (input, simple
//   ops and absolute values, squares, sum), 32 square-root stages, one divider
//   setup stage, 32 divider stages and the output register.
//   One item is accepted per cycle unless stalled; the long path is the 32-step
//   square root followed by the 32-step quotient of the normalize divider.
//   The whole pipeline advances together: when the output register holds an
//   item the receiver has not taken, s_axis_tready_o drops and every stage
//   holds, so nothing is lost or repeated.
//   Reset clears all valid bits; the block keeps no other state.
`include "assert_macros.svh"
module vec3_arithmetic_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [191:0]  s_axis_tdata_i,  // a_x, a_y, a_z, b_x, b_y, b_z
  input  logic [2:0]    s_axis_tuser_i,  // req_type
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [127:0]  m_axis_tdata_o,  // res_x, res_y, res_z, scalar_out
  output logic [2:0]    m_axis_tuser_o   // test_flag, status[1:0]
);

  logic             en;
  logic [2:0][31:0] a_in, b_in;
  logic             vf, vs, vd;
  v3au_pkg::item_t  itf, its;
  logic [63:0]      sum;
  logic [31:0]      root;
  logic [2:0][31:0] res;
  logic [31:0]      scalar;
  logic             flag;
  logic [1:0]       status;

  // Global advance: hold everything while the output waits
  assign en              = !vd || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Unpack input item
  assign a_in = s_axis_tdata_i[95:0];
  assign b_in = s_axis_tdata_i[191:96];

  v3au_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .op_i    (v3au_pkg::op_e'(s_axis_tuser_i)),
    .a_i     (a_in),
    .b_i     (b_in),
    .valid_o (vf),
    .item_o  (itf),
    .sum_o   (sum)
  );

  v3au_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vf),
    .item_i  (itf),
    .sum_i   (sum),
    .valid_o (vs),
    .item_o  (its),
    .root_o  (root)
  );

  v3au_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vs),
    .item_i   (its),
    .root_i   (root),
    .valid_o  (vd),
    .res_o    (res),
    .scalar_o (scalar),
    .flag_o   (flag),
    .status_o (status)
  );

  // Pack output item
  assign m_axis_tvalid_o = vd;
  assign m_axis_tdata_o  = {scalar, res};
  assign m_axis_tuser_o  = {status, flag};

  // Checks
  `V3AU_NEVER(a_status_code, vd && (status == 2'd3), "undefined status code")
  `V3AU_ASSERT(a_dz_zero, vd && (status == v3au_pkg::ST_DZ) |-> (res == '0) && (scalar == '0), "divide by zero result not zero")
  `V3AU_ASSERT(a_scalar_only, vd && (scalar != '0) |-> (res == '0) && !flag, "scalar result mixed with vector")
  `V3AU_ASSERT(a_flag_only, vd && flag |-> (res == '0) && (status == v3au_pkg::ST_OK), "test flag mixed with other result")

endmodule

// File: sim/vec3_arithmetic_unit_core_test.sv
// Testbench for vec3_arithmetic_unit_core: directed and random vector requests,
// results predicted in-bench and checked in order. Depends on v3au_pkg and the RTL.
`timescale 1ns / 100ps

class vec_scoreboard;
  logic [127:0] exp_data[$];
  logic [2:0]   exp_user[$];
  int           errors;

  // Clamp a wide signed value to 32 bits
  static function logic [31:0] clamp32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Floor square root of a 64-bit value by bisection
  static function longint unsigned root64(input longint unsigned n);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'h1_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // Exact floor magnitude, saturating at 2^32-1
  static function longint unsigned vec_length(input longint c[3], inout bit sat);
    logic [65:0] sum;
    longint unsigned m;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = (c[i] < 0) ? -c[i] : c[i];
      if (m >= 64'h1_0000_0000) begin
        sat = 1;
        return 64'hFFFF_FFFF;
      end
      sum += 66'(m) * 66'(m);
    end
    if (sum[65:64] != 0) begin
      sat = 1;
      return 64'hFFFF_FFFF;
    end
    return root64(sum[63:0]);
  endfunction

  // Work out the result of one accepted request
  function void note_request(input logic [191:0] d, input v3au_pkg::op_e op);
    longint a[3], b[3], dif[3], mag;
    logic [31:0] r[3];
    logic [31:0] scalar;
    bit flag, sat;
    logic [1:0] st;
    flag = 0; sat = 0; scalar = 0; st = v3au_pkg::ST_OK;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(d[32*i +: 32]));
      b[i] = longint'($signed(d[96 + 32*i +: 32]));
      dif[i] = a[i] - b[i];
      r[i] = 0;
    end
    case (op)
      v3au_pkg::OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], sat);
      v3au_pkg::OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(dif[i], sat);
      v3au_pkg::OP_NEG: for (int i = 0; i < 3; i++) r[i] = clamp32(-a[i], sat);
      v3au_pkg::OP_EQ:  flag = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      v3au_pkg::OP_ZERO: flag = (a[0] == 0) && (a[1] == 0) && (a[2] == 0);
      v3au_pkg::OP_MAG: scalar = 32'(vec_length(a, sat));
      v3au_pkg::OP_NORM: begin
        mag = vec_length(a, sat);
        if (mag == 0) st = v3au_pkg::ST_DZ;
        else for (int i = 0; i < 3; i++) r[i] = clamp32((a[i] * 65536) / mag, sat);
      end
      default: scalar = 32'(vec_length(dif, sat));
    endcase
    if (st == v3au_pkg::ST_OK && sat) st = v3au_pkg::ST_SAT;
    exp_data.push_back({scalar, r[2], r[1], r[0]});
    exp_user.push_back({st, flag});
  endfunction

  function void check_result(input logic [127:0] d, input logic [2:0] u);
    logic [127:0] ed;
    logic [2:0] eu;
    if (exp_data.size() == 0) begin
      $display("%0t: result with nothing expected: data %h user %h", $time, d, u);
      errors++;
      return;
    end
    ed = exp_data.pop_front();
    eu = exp_user.pop_front();
    for (int i = 0; i < 4; i++)
      if (d[32*i +: 32] !== ed[32*i +: 32]) begin
        $display("%0t: word %0d expected %h actual %h", $time, i, ed[32*i +: 32],
                 d[32*i +: 32]);
        errors++;
      end
    if (u[0] !== eu[0]) begin
      $display("%0t: test_flag expected %b actual %b", $time, eu[0], u[0]);
      errors++;
    end
    if (u[2:1] !== eu[2:1]) begin
      $display("%0t: status expected %0d actual %0d", $time, eu[2:1], u[2:1]);
      errors++;
    end
  endfunction
endclass

module vec3_arithmetic_unit_core_test;

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid_i = 0, m_axis_tready_i = 0;
  logic s_axis_tready_o, m_axis_tvalid_o;
  logic [191:0] s_axis_tdata_i = '0;  // a_x, a_y, a_z, b_x, b_y, b_z
  logic [2:0]   s_axis_tuser_i = '0;  // req_type
  logic [127:0] m_axis_tdata_o;       // res_x, res_y, res_z, scalar_out
  logic [2:0]   m_axis_tuser_o;       // test_flag, status[1:0]

  int send_idle_pct, recv_stall_pct;
  vec_scoreboard results = new();

  vec3_arithmetic_unit_core dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // Receiver: random stalls, check on each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) results.check_result(m_axis_tdata_o, m_axis_tuser_o);
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(input v3au_pkg::op_e op, input logic [191:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    results.note_request(d, op);
  endtask

  // Random component: extremes, small values or anything
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF - $urandom_range(2);
      1: return 32'h8000_0000 + $urandom_range(2);
      2: return 32'($signed($urandom_range(8)) - 4);
      3: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [191:0] rand_vectors();
    logic [191:0] d;
    for (int i = 0; i < 6; i++) d[32*i +: 32] = rand_comp();
    if ($urandom_range(3) == 0) d[191:96] = d[95:0];   // equal vectors
    if ($urandom_range(7) == 0) d[95:0] = '0;           // zero first vector
    return d;
  endfunction

  initial begin
    #600000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [31:0] mx, mn;
    mx = v3au_pkg::S32_MAX;
    mn = v3au_pkg::S32_MIN;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: every operation, overflow, minimum negate, zero normalize, far distance
    for (int o = 0; o < 8; o++) begin
      send_request(v3au_pkg::op_e'(o), {mx, mx, mx, mx, mx, mx});
      send_request(v3au_pkg::op_e'(o), {mx, mx, mx, mn, mn, mn});
      send_request(v3au_pkg::op_e'(o), '0);
    end
    send_request(v3au_pkg::OP_NORM, {96'h0, 32'h0, 32'h0, 32'h0001_0000});
    send_request(v3au_pkg::OP_MAG, {96'h0, 32'h0, 32'h0, 32'h0000_0003});

    // Pause until the pipeline has drained
    s_axis_tvalid_i <= 0;
    while (results.exp_data.size() != 0) @(posedge clk_i);

    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (350) send_request(v3au_pkg::op_e'($urandom_range(7)), rand_vectors());
    end
    s_axis_tvalid_i <= 0;
    recv_stall_pct = 0;

    while (results.exp_data.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (results.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/v3au_pkg.sv
sv/v3au_front.sv
sv/v3au_sqrt.sv
sv/v3au_div.sv
sv/vec3_arithmetic_unit_core.sv
sim/vec3_arithmetic_unit_core_test.sv
